// ===== design/plc_pkg.sv =====
// Shared types and constants for the piecewise linear curve evaluator.
// No dependencies; every other file of the block but plc_ram imports this package.
package plc_pkg;

  // Fixed field widths of the request, response and register port
  localparam int POINT_INDEX_W = 4;
  localparam int COUNT_W       = 5;
  localparam int COORD_W       = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  // Request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT = 3'd0,
    CFG_WRAP_MODE   = 3'd1,
    CFG_X_MIN       = 3'd2,
    CFG_X_MAX       = 3'd3,
    CFG_Y_MIN       = 3'd4,
    CFG_Y_MAX       = 3'd5
  } cfg_reg_e;

  // Status of the shared divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/plc_if.sv =====
// Handshake channels of the curve evaluator: request, response and register write.
// Depends on plc_pkg for the fixed field widths.
interface plc_in_if #(parameter int FRAC_BITS = 16);
  import plc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [POINT_INDEX_W-1:0]  point_index;
  logic [FRAC_BITS:0]        point_x;
  logic [FRAC_BITS:0]        point_y;
  logic signed [COORD_W-1:0] x_value;
  modport source (output valid, kind, point_index, point_x, point_y, x_value, input ready);
  modport sink   (input valid, kind, point_index, point_x, point_y, x_value, output ready);
endinterface

interface plc_out_if;
  import plc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] y_value;
  modport source (output valid, y_value, input ready);
  modport sink   (input valid, y_value, output ready);
endinterface

interface plc_cfg_if;
  import plc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/plc_ram.sv =====
// Generic single write port RAM with one registered read port.
// No dependencies.
module plc_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port; the registered read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/plc_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the evaluator.
// Depends on plc_pkg for the status struct.
module plc_div #(
  parameter int DVW = 17,
  parameter int QW  = 17
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DVW+QW-1:0]      dividend_i,
  input  logic [DVW-1:0]         divisor_i,
  output plc_pkg::div_stat_t     stat_o,
  output logic [QW-1:0]          quotient_o
);
  import plc_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic [DVW-1:0] rem_q;
  logic [QW-1:0]  low_q;
  logic [DVW-1:0] dvs_q;
  logic [CW-1:0]  cnt_q;
  logic           done_q;
  logic [DVW:0]   trial;
  logic [DVW:0]   diff;
  logic           fits;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign trial = {rem_q, low_q[QW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  // Step counter and completion flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(QW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DVW+QW-1:QW];
      low_q <= dividend_i[QW-1:0];
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
      low_q <= {low_q[QW-2:0], fits};
    end
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quotient_o  = low_q;

endmodule

// ===== design/piecewise_linear_curve_eval.sv =====
// Piecewise linear transfer curve evaluator. A point write request leaves the block ready
// at once. An evaluate request runs through the prepare, first division, table scan,
// subtract, multiply, second division and output states; an extra read state follows the
// scan when the seam left of the first point is crossed. Equal x bounds skip the first
// division, and an end held without wrap or a zero-width segment skips the second. One
// shared restoring divider gives one quotient bit per cycle, first for the unit position
// and then for the height change within the segment, and the segment search reads one
// table entry per cycle from the point RAM. The block is not ready while an evaluation
// runs; a finished result sits in the output register and the next request is taken
// while it waits. A result that finds that register still full waits in the output state
// until the register is freed.
// Depends on plc_pkg, plc_if, plc_ram and plc_div.
module piecewise_linear_curve_eval #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  plc_in_if.sink    in_i,
  plc_out_if.source out_o,
  plc_cfg_if.sink   cfg_i
);
  import plc_pkg::*;

  localparam int UW  = FRAC_BITS + 1;
  localparam int SW  = FRAC_BITS + 3;
  localparam int TW  = FRAC_BITS + 2;
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int EW  = 2 * UW;
  localparam int DVW = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
  localparam int NW  = DVW + UW;
  localparam int PW  = FRAC_BITS + 19;
  localparam logic [UW-1:0] ONE_U = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [SW-1:0] ONE_S = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_PREP   = 9'b000000010,
    ST_DIV1   = 9'b000000100,
    ST_SCAN   = 9'b000001000,
    ST_WRAPRD = 9'b000010000,
    ST_SUB    = 9'b000100000,
    ST_MUL1   = 9'b001000000,
    ST_DIV2   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

  // Configuration registers
  logic [COUNT_W-1:0]        pc_q;
  logic                      wrap_q;
  logic signed [COORD_W-1:0] xmin_q, xmax_q, ymin_q, ymax_q;

  // Control
  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q;
  logic          out_valid_q;

  // Datapath
  logic signed [COORD_W-1:0] xc_q;
  logic [UW-1:0]             u_q, h_q;
  logic [UW-1:0]             first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [SW-1:0]      lx_q, rx_q;
  logic [UW-1:0]             ly_q, ry_q;
  logic [TW-1:0]             t_q, dx_q;
  logic [UW-1:0]             dym_q;
  logic                      dyneg_q;
  logic signed [PW-1:0]      p2_q;
  logic                      mul2_q;
  logic signed [COORD_W-1:0] y_q;

  // Combinational helpers
  logic                      in_acc, wr_en;
  logic [AW-1:0]             last_idx, rd_addr;
  logic [EW-1:0]             wdata, rdata;
  logic [UW-1:0]             ex, ey, fx, fy;
  logic                      hit, is_last;
  logic signed [COORD_W-1:0] lo_b, hi_b, xcl;
  logic signed [16:0]        num17, den17, numa, dena;
  logic                      div_start;
  logic [NW-1:0]             div_dvd;
  logic [DVW-1:0]            div_dvs;
  div_stat_t                 div_stat;
  logic [UW-1:0]             div_q;
  logic signed [SW-1:0]      t_s, dx_s;
  logic signed [TW-1:0]      dy_s, dy_a;
  logic signed [SW-1:0]      hs;
  logic [UW-1:0]             h_sat;
  logic signed [16:0]        dyb;
  logic signed [18:0]        ysum;
  logic                      out_free;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_free  = !out_valid_q || out_o.ready;

  // Clamp the point count to 1..MAX_POINTS and form the last index
  always_comb begin
    if (pc_q == '0) begin
      last_idx = '0;
    end else if (int'(pc_q) > MAX_POINTS) begin
      last_idx = AW'(MAX_POINTS - 1);
    end else begin
      last_idx = AW'(pc_q - COUNT_W'(1));
    end
  end

  // Saturate a written point to one and store it
  assign wr_en = in_acc && (in_i.kind == KIND_WRITE) && (int'(in_i.point_index) < MAX_POINTS);
  assign wdata = {(in_i.point_x > ONE_U) ? ONE_U : in_i.point_x,
                  (in_i.point_y > ONE_U) ? ONE_U : in_i.point_y};

  plc_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(in_i.point_index)),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign ex = rdata[EW-1:UW];
  assign ey = rdata[UW-1:0];
  assign fx = (cnt_q == '0) ? ex : first_x_q;
  assign fy = (cnt_q == '0) ? ey : first_y_q;
  assign hit     = (u_q <= ex);
  assign is_last = (cnt_q == last_idx);

  // Fetch the next entry, or the last one when wrapping left of the first point
  always_comb begin
    if (state_q == ST_SCAN) begin
      rd_addr = (hit && cnt_q == '0 && wrap_q) ? last_idx : cnt_q + AW'(1);
    end else begin
      rd_addr = '0;
    end
  end

  // Clamp x between the smaller and larger bound
  assign lo_b = (xmin_q < xmax_q) ? xmin_q : xmax_q;
  assign hi_b = (xmin_q < xmax_q) ? xmax_q : xmin_q;
  assign xcl  = (in_i.x_value < lo_b) ? lo_b : ((in_i.x_value > hi_b) ? hi_b : in_i.x_value);

  // Offset and span magnitudes for the unit position
  assign num17 = 17'(xc_q) - 17'(xmin_q);
  assign den17 = 17'(xmax_q) - 17'(xmin_q);
  assign numa  = den17[16] ? -num17 : num17;
  assign dena  = den17[16] ? -den17 : den17;

  // Segment differences
  assign t_s  = SW'($signed({2'b00, u_q})) - lx_q;
  assign dx_s = rx_q - lx_q;
  assign dy_s = $signed({1'b0, ry_q}) - $signed({1'b0, ly_q});
  assign dy_a = dy_s[TW-1] ? -dy_s : dy_s;

  // Divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_dvd   = NW'({numa[15:0], {FRAC_BITS{1'b0}}});
    div_dvs   = DVW'(dena[15:0]);
    if (state_q == ST_PREP) begin
      div_start = (den17 != '0) && !div_stat.busy;
    end else if (state_q == ST_MUL1) begin
      div_start = !div_stat.busy;
      div_dvd   = NW'(t_q * dym_q);
      div_dvs   = DVW'(dx_q);
    end
  end

  plc_div #(.DVW(DVW), .QW(UW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .stat_o     (div_stat),
    .quotient_o (div_q)
  );

  // Apply the signed quotient to the left height and saturate to 0..one
  assign hs    = $signed({2'b00, ly_q}) + (dyneg_q ? -SW'($signed({2'b00, div_q}))
                                                   : SW'($signed({2'b00, div_q})));
  assign h_sat = hs[SW-1] ? '0 : ((hs > ONE_S) ? ONE_U : hs[UW-1:0]);

  // Scale to the y bounds
  assign dyb  = 17'(ymax_q) - 17'(ymin_q);
  assign ysum = 19'(ymin_q) + p2_q[PW-1:FRAC_BITS];

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.kind == KIND_EVAL) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = (den17 == '0) ? ST_SCAN : ST_DIV1;
      end
      ST_DIV1: begin
        if (div_stat.done) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit) begin
          if (cnt_q != '0) begin
            state_d = ST_SUB;
          end else begin
            state_d = wrap_q ? ST_WRAPRD : ST_OUT;
          end
        end else if (is_last) begin
          state_d = wrap_q ? ST_SUB : ST_OUT;
        end
      end
      ST_WRAPRD: state_d = ST_SUB;
      ST_SUB: begin
        state_d = (dx_s == '0) ? ST_OUT : ST_MUL1;
      end
      ST_MUL1:   state_d = ST_DIV2;
      ST_DIV2: begin
        if (div_stat.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (mul2_q && out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      mul2_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != ST_SCAN) begin
        cnt_q <= '0;
      end else if (!hit && !is_last) begin
        cnt_q <= cnt_q + AW'(1);
      end
      // The scale product is registered in OUT before the sum is formed from it
      if (state_q == ST_OUT) begin
        mul2_q <= !(mul2_q && out_free);
      end
      if (state_q == ST_OUT && mul2_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= COUNT_W'(2);
      wrap_q <= 1'b0;
      xmin_q <= '0;
      xmax_q <= COORD_W'(255);
      ymin_q <= '0;
      ymax_q <= COORD_W'(255);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_POINT_COUNT: pc_q   <= cfg_i.data[COUNT_W-1:0];
        CFG_WRAP_MODE:   wrap_q <= cfg_i.data[0];
        CFG_X_MIN:       xmin_q <= $signed(cfg_i.data);
        CFG_X_MAX:       xmax_q <= $signed(cfg_i.data);
        CFG_Y_MIN:       ymin_q <= $signed(cfg_i.data);
        CFG_Y_MAX:       ymax_q <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        xc_q <= xcl;
      end
      ST_PREP: begin
        u_q <= '0;
      end
      ST_DIV1: begin
        if (div_stat.done) u_q <= div_q;
      end
      ST_SCAN: begin
        if (cnt_q == '0) begin
          first_x_q <= ex;
          first_y_q <= ey;
        end
        if (hit) begin
          if (cnt_q != '0) begin
            lx_q <= $signed({2'b00, prev_x_q});
            ly_q <= prev_y_q;
            rx_q <= $signed({2'b00, ex});
            ry_q <= ey;
          end else if (wrap_q) begin
            rx_q <= $signed({2'b00, ex});
            ry_q <= ey;
          end else begin
            h_q <= ey;
          end
        end else if (is_last) begin
          if (wrap_q) begin
            lx_q <= $signed({2'b00, ex});
            ly_q <= ey;
            rx_q <= $signed({2'b00, fx}) + ONE_S;
            ry_q <= fy;
          end else begin
            h_q <= ey;
          end
        end else begin
          prev_x_q <= ex;
          prev_y_q <= ey;
        end
      end
      ST_WRAPRD: begin
        lx_q <= $signed({2'b00, ex}) - ONE_S;
        ly_q <= ey;
      end
      ST_SUB: begin
        t_q     <= t_s[TW-1:0];
        dx_q    <= dx_s[TW-1:0];
        dym_q   <= dy_a[UW-1:0];
        dyneg_q <= dy_s[TW-1];
        h_q     <= ry_q;
      end
      ST_DIV2: begin
        if (div_stat.done) h_q <= h_sat;
      end
      ST_OUT: begin
        p2_q <= PW'($signed({1'b0, h_q}) * dyb);
        if (mul2_q && out_free) y_q <= ysum[COORD_W-1:0];
      end
      default: ;
    endcase
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.y_value = y_q;

endmodule

// ===== design/plc_chk.sv =====
// Port-level checks on the curve evaluator, bound to its top level.
// Depends on piecewise_linear_curve_eval and its interface ports.
module plc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_kind_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_y_value_i,
  input logic        cfg_ready_i
);
  import plc_pkg::*;

  // Hold a stalled response steady
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_y_value_i))
    else $error("stalled response changed or dropped");

  // Keep taking requests after a point write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_kind_i == KIND_WRITE |=> in_ready_i)
    else $error("ready dropped after a point write");

  // Drop ready while an evaluation is under way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_kind_i == KIND_EVAL |=> !in_ready_i)
    else $error("ready held during an evaluation");

  // Register port never back-pressures
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("register port not ready");

endmodule

bind piecewise_linear_curve_eval plc_chk u_plc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_kind_i     (in_i.kind),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_y_value_i (out_o.y_value),
  .cfg_ready_i   (cfg_i.ready)
);

// ===== tb/sv/piecewise_linear_curve_eval_tb.sv =====
// Self-checking testbench for the piecewise linear curve evaluator.
// Depends on plc_pkg, plc_if and the piecewise_linear_curve_eval RTL.
`timescale 1ns / 1ps

module piecewise_linear_curve_eval_tb;
  import plc_pkg::*;

  localparam int     MAX_PTS       = 16;
  localparam int     FRAC          = 16;
  localparam int     PT_W          = FRAC + 1;
  localparam int     UNIT_I        = 1 << FRAC;
  localparam longint UNIT          = 64'sd1 << FRAC;
  localparam int     RAW_MAX       = (1 << (FRAC + 1)) - 1;
  localparam int     RESET_CYCLES  = 9;
  localparam int     SETTLE_CYCLES = 150;
  localparam int     CYCLE_LIMIT   = 1_000_000;
  localparam int     RANDOM_ITEMS  = 900;
  localparam int     IDLE_PCT      = 36;
  localparam int     CALM_FROM     = 20_000;
  localparam int     CALM_TO       = 32_000;
  localparam int     HOLD_AFTER    = 100;
  localparam int     HOLD_CYCLES   = 500;

  typedef struct {
    logic                      kind;
    logic [POINT_INDEX_W-1:0]  point_index;
    logic [FRAC:0]             point_x;
    logic [FRAC:0]             point_y;
    logic signed [COORD_W-1:0] x_value;
  } curve_req_t;

  // Curve predictor and store of expected outputs
  class curve_scoreboard;
    longint                    knot_x[MAX_PTS];
    longint                    knot_y[MAX_PTS];
    logic [COUNT_W-1:0]        count_reg;
    bit                        wrap_on;
    logic signed [COORD_W-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic signed [COORD_W-1:0] expected_y[$];
    int unsigned               mismatches;
    int unsigned               matched;

    function new();
      count_reg = 5'd2;
      wrap_on   = 1'b0;
      xmin_reg  = 16'sd0;
      xmax_reg  = 16'sd255;
      ymin_reg  = 16'sd0;
      ymax_reg  = 16'sd255;
      foreach (knot_x[i]) begin
        knot_x[i] = 0;
        knot_y[i] = 0;
      end
      mismatches = 0;
      matched    = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_POINT_COUNT: count_reg = data[COUNT_W-1:0];
        CFG_WRAP_MODE:   wrap_on   = data[0];
        CFG_X_MIN:       xmin_reg  = data;
        CFG_X_MAX:       xmax_reg  = data;
        CFG_Y_MIN:       ymin_reg  = data;
        CFG_Y_MAX:       ymax_reg  = data;
        default: ;
      endcase
    endfunction

    function int active_points();
      int n;
      n = int'(count_reg);
      if (n < 1) n = 1;
      if (n > MAX_PTS) n = MAX_PTS;
      return n;
    endfunction

    function longint clip_unit(logic [FRAC:0] v);
      return (v > UNIT) ? UNIT : longint'(v);
    endfunction

    // Clamp, map to unit space, search the segment, interpolate and scale
    function logic signed [COORD_W-1:0] curve_value(logic signed [COORD_W-1:0] xv);
      longint x, xa, xb, lo, hi, u, h, lx, ly, rx, ry, dx, num, den, res;
      int     n, c;
      x  = longint'(xv);
      xa = longint'(xmin_reg);
      xb = longint'(xmax_reg);
      lo = (xa < xb) ? xa : xb;
      hi = (xa < xb) ? xb : xa;
      n  = active_points();
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      u = 0;
      if (xa != xb) begin
        num = x - xa;
        den = xb - xa;
        if (den < 0) begin
          num = -num;
          den = -den;
        end
        u = (num * UNIT) / den;
      end
      c = 0;
      while (c < n && u > knot_x[c]) c++;
      if (c == 0 && !wrap_on) begin
        h = knot_y[0];
      end else if (c == n && !wrap_on) begin
        h = knot_y[n-1];
      end else begin
        // across the seam the far end point is shifted by one unit
        if (c == 0) begin
          lx = knot_x[n-1] - UNIT;
          ly = knot_y[n-1];
        end else begin
          lx = knot_x[c-1];
          ly = knot_y[c-1];
        end
        if (c == n) begin
          rx = knot_x[0] + UNIT;
          ry = knot_y[0];
        end else begin
          rx = knot_x[c];
          ry = knot_y[c];
        end
        dx = rx - lx;
        h  = (dx == 0) ? ry : ly + ((u - lx) * (ry - ly)) / dx;
      end
      if (h < 0) h = 0;
      if (h > UNIT) h = UNIT;
      res = longint'(ymin_reg) + ((h * (longint'(ymax_reg) - longint'(ymin_reg))) >>> FRAC);
      return res[COORD_W-1:0];
    endfunction

    function void note_request(curve_req_t r);
      if (r.kind == KIND_WRITE) begin
        knot_x[r.point_index] = clip_unit(r.point_x);
        knot_y[r.point_index] = clip_unit(r.point_y);
      end else begin
        expected_y.push_back(curve_value(r.x_value));
      end
    endfunction

    function void check_result(logic signed [COORD_W-1:0] y);
      logic signed [COORD_W-1:0] want;
      if (expected_y.size() == 0) begin
        $error("y_value: expected none, actual %0d", y);
        mismatches++;
      end else begin
        want = expected_y.pop_front();
        if (y !== want) begin
          $error("y_value: expected %0d, actual %0d", want, y);
          mismatches++;
        end else begin
          matched++;
        end
      end
    endfunction

    function int pending();
      return expected_y.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned settings_applied = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  curve_scoreboard sb = new();

  plc_in_if #(.FRAC_BITS(FRAC)) in_if ();
  plc_out_if                    out_if ();
  plc_cfg_if                    cfg_if ();

  piecewise_linear_curve_eval #(
    .MAX_POINTS(MAX_PTS),
    .FRAC_BITS (FRAC)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #5 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit calm_window();
    return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
  endfunction

  // Response side: random back-pressure and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (!hold_done && sb.matched >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Check each response at the half cycle before its handshake edge
  always @(negedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.y_value);
  end

  task automatic send_request(input curve_req_t r);
    while (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= r.kind;
    in_if.point_index <= r.point_index;
    in_if.point_x     <= r.point_x;
    in_if.point_y     <= r.point_y;
    in_if.x_value     <= r.x_value;
    do @(negedge clk); while (!in_if.ready);
    @(posedge clk);
    sb.note_request(r);
    requests_sent++;
  endtask

  task automatic send_point(input int idx, input int px, input int py);
    curve_req_t r;
    r.kind        = KIND_WRITE;
    r.point_index = POINT_INDEX_W'(idx);
    r.point_x     = PT_W'(px);
    r.point_y     = PT_W'(py);
    r.x_value     = COORD_W'($urandom);
    send_request(r);
  endtask

  task automatic send_eval(input int xv);
    curve_req_t r;
    r.kind        = KIND_EVAL;
    r.point_index = POINT_INDEX_W'($urandom);
    r.point_x     = PT_W'($urandom);
    r.point_y     = PT_W'($urandom);
    r.x_value     = COORD_W'(xv);
    send_request(r);
  endtask

  // Hold until every result is back, then let a trailing write finish
  task automatic drain_and_settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(negedge clk); while (!cfg_if.ready);
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic apply_settings(input logic [15:0] cnt, input logic [15:0] wrp,
                                input logic [15:0] xa, input logic [15:0] xb,
                                input logic [15:0] ya, input logic [15:0] yb);
    write_register(CFG_POINT_COUNT, cnt);
    write_register(CFG_WRAP_MODE, wrp);
    write_register(CFG_X_MIN, xa);
    write_register(CFG_X_MAX, xb);
    write_register(CFG_Y_MIN, ya);
    write_register(CFG_Y_MAX, yb);
    cfg_if.valid <= 1'b0;
    settings_applied++;
  endtask

  // Extremes first, then random bounds with the odd out-of-range count
  task automatic choose_settings(input int phase);
    logic [15:0] cnt, xa, xb, ya, yb;
    bit          w;
    int          pick;
    case (phase)
      0: begin
        cnt = 16; w = 1'b1; xa = 16'h8000; xb = 16'h7fff; ya = 16'h8000; yb = 16'h7fff;
      end
      1: begin
        cnt = 1; w = 1'b0; xa = 16'h7fff; xb = 16'h8000; ya = 16'h7fff; yb = 16'h8000;
      end
      2: begin
        cnt = 0; w = 1'b1; xa = 16'($urandom); xb = xa; ya = 16'($urandom);
        yb = 16'($urandom);
      end
      3: begin
        cnt = 31; w = 1'b0; xa = 16'h8000; xb = 16'h7fff; ya = 16'($urandom); yb = ya;
      end
      default: begin
        cnt  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(16, 31))
                                           : 16'($urandom_range(1, 16));
        if ($urandom_range(0, 19) == 0) cnt = 0;
        w    = 1'($urandom);
        pick = $urandom_range(0, 9);
        xa   = 16'($urandom);
        if (pick < 4) xb = 16'($urandom);
        else if (pick < 9) xb = xa + 16'($urandom_range(0, 600)) - 16'd300;
        else xb = xa;
        ya   = 16'($urandom);
        yb   = 16'($urandom);
      end
    endcase
    apply_settings(cnt, 16'(w), xa, xb, ya, yb);
  endtask

  // Mostly inside the x bounds, the ends themselves now and then
  function automatic int pick_x();
    int lo, hi, sel;
    lo  = (sb.xmin_reg < sb.xmax_reg) ? int'(sb.xmin_reg) : int'(sb.xmax_reg);
    hi  = (sb.xmin_reg < sb.xmax_reg) ? int'(sb.xmax_reg) : int'(sb.xmin_reg);
    sel = $urandom_range(0, 19);
    if (sel < 6) return $urandom;
    if (sel == 6) return lo;
    if (sel == 7) return hi;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Load a table (sorted, or scrambled noise) and evaluate across it
  task automatic run_curve_phase(input bit sorted_table);
    int xs[];
    int n, evals, px, py;
    n  = sb.active_points();
    xs = new[n];
    foreach (xs[i]) xs[i] = $urandom_range(0, UNIT_I);
    xs.sort();
    if ($urandom_range(0, 3) == 0) xs[0] = 0;
    if ($urandom_range(0, 3) == 0) xs[n-1] = UNIT_I;
    for (int i = 1; i < n; i++) if ($urandom_range(0, 7) == 0) xs[i] = xs[i-1];
    for (int i = 0; i < n; i++) begin
      px = xs[i];
      if (px == UNIT_I && $urandom_range(0, 1) == 1) px = $urandom_range(UNIT_I, RAW_MAX);
      if (!sorted_table) px = $urandom_range(0, RAW_MAX);
      py = ($urandom_range(0, 7) == 0) ? $urandom_range(0, RAW_MAX) : $urandom_range(0, UNIT_I);
      send_point(i, px, py);
    end
    evals = $urandom_range(15, 30);
    for (int i = 0; i < evals; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_point($urandom_range(0, MAX_PTS - 1), $urandom_range(0, RAW_MAX),
                   $urandom_range(0, RAW_MAX));
      else
        send_eval(pick_x());
    end
  endtask

  initial begin
    int phase;
    int unsigned start_count;
    in_if.valid       <= 1'b0;
    in_if.kind        <= KIND_WRITE;
    in_if.point_index <= '0;
    in_if.point_x     <= '0;
    in_if.point_y     <= '0;
    in_if.x_value     <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CFG_POINT_COUNT;
    cfg_if.data       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: ends, inside, zero-width segment, saturated and unsorted points
    send_point(0, 16384, 0);
    send_point(1, 49152, UNIT_I);
    send_eval(-32768);
    send_eval(32767);
    send_eval(0);
    send_eval(128);
    send_point(1, 16384, RAW_MAX);
    send_eval(64);
    send_point(0, RAW_MAX, UNIT_I - 1);
    send_eval(200);
    send_point(15, 0, 0);
    drain_and_settle();

    // Wrap on: seam on both sides of the table
    apply_settings(16'd2, 16'd1, 16'd0, 16'd255, 16'd0, 16'd255);
    send_point(0, 16384, 0);
    send_point(1, 49152, UNIT_I);
    send_eval(0);
    send_eval(255);
    send_eval(100);
    drain_and_settle();

    // Equal x bounds with reversed y bounds
    apply_settings(16'd2, 16'd0, 16'hfffb, 16'hfffb, 16'd1000, 16'hfc18);
    send_eval(1234);
    send_eval(-32768);

    // Random phases: mostly well-formed tables, some scrambled ones
    start_count = requests_sent;
    phase = 0;
    while (requests_sent - start_count < RANDOM_ITEMS) begin
      drain_and_settle();
      choose_settings(phase);
      run_curve_phase($urandom_range(0, 4) != 0);
      phase++;
    end

    drain_and_settle();
    $display("Covered %0d requests and %0d checked curve outputs over %0d register settings.",
             requests_sent, sb.matched, settings_applied);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
